[rtl/core/cxl_pkg.sv]
`default_nettype none

package cxl_pkg;

  // cube geometry
  localparam int unsigned CUBE_W       = 32;
  localparam int unsigned NUM_VARS     = 32;
  localparam int unsigned SLOT_COUNT   = 4;
  localparam int unsigned DIST_W       = 3;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned CODE_IDX_W   = 4;

  localparam logic [DIST_W-1:0] MAX_DISTANCE = 3'd4;

  // literals beyond the variable count are forced to zero
  localparam logic [CUBE_W-1:0] VAR_MASK = {CUBE_W{1'b1}} >> (CUBE_W - NUM_VARS);

  // per-visit choice codes
  localparam logic [1:0] CODE_KEEP  = 2'd0;
  localparam logic [1:0] CODE_COPY  = 2'd1;
  localparam logic [1:0] CODE_MERGE = 2'd2;

  typedef logic [CUBE_W-1:0] cube_w_t;

  // payload travelling through the position scan stages
  typedef struct packed {
    cube_w_t                    b0;
    cube_w_t                    m0;
    cube_w_t                    b1;
    cube_w_t                    m1;
    cube_w_t                    left;
    cube_w_t [SLOT_COUNT-1:0]   pos;
    logic [DIST_W-1:0]          span;
    logic [CODE_W-1:0]          codes;
  } scan_t;

  // one finished result item
  typedef struct packed {
    cube_w_t [SLOT_COUNT-1:0]   rbits;
    cube_w_t [SLOT_COUNT-1:0]   rmask;
    logic [DIST_W-1:0]          count;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/cxl_if.sv]
`default_nettype none

interface cxl_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] first_cube_bits;
  logic [31:0] first_cube_mask;
  logic [31:0] second_cube_bits;
  logic [31:0] second_cube_mask;
  logic [2:0]  link_distance;
  logic [31:0] choice_codes;

  modport source (
    output valid, first_cube_bits, first_cube_mask, second_cube_bits,
           second_cube_mask, link_distance, choice_codes,
    input  ready
  );
  modport sink (
    input  valid, first_cube_bits, first_cube_mask, second_cube_bits,
           second_cube_mask, link_distance, choice_codes,
    output ready
  );
endinterface

interface cxl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out0_bits;
  logic [31:0] out0_mask;
  logic [31:0] out1_bits;
  logic [31:0] out1_mask;
  logic [31:0] out2_bits;
  logic [31:0] out2_mask;
  logic [31:0] out3_bits;
  logic [31:0] out3_mask;
  logic [2:0]  valid_count;

  modport source (
    output valid, out0_bits, out0_mask, out1_bits, out1_mask, out2_bits,
           out2_mask, out3_bits, out3_mask, valid_count,
    input  ready
  );
  modport sink (
    input  valid, out0_bits, out0_mask, out1_bits, out1_mask, out2_bits,
           out2_mask, out3_bits, out3_mask, valid_count,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/cube_exorlink_unit.sv]
`default_nettype none

// cube_exorlink_unit: exorlink transform of two product cubes over up to 32
// variables. Each input item carries two cubes (polarity bits and care mask),
// a link distance (values above 4 count as 4) and sixteen 2-bit choice codes;
// each item yields exactly one result item with up to four result cubes and
// valid_count equal to the effective distance, unused slots reading zero.
// The block is a four-stage pipeline (order/swap, two position-scan stages,
// compose into the output register): an item can be accepted every cycle
// while nothing backs up, and its result passes the order, both scan and
// compose registers before it is offered. A stall on the output holds every
// full stage in place; bubbles are squeezed out so in_i.ready drops only
// when all four stages hold items and the output is not taken.

module cube_exorlink_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cxl_in_if.sink     in_i,
  cxl_out_if.source  out_o
);
  import cxl_pkg::*;

  // stage 1 -> stage 2
  logic  ord_valid, ord_ready;
  scan_t ord_data;
  // stage 2 -> stage 3
  logic  scan_a_valid, scan_a_ready;
  scan_t scan_a_data;
  // stage 3 -> stage 4
  logic  scan_b_valid, scan_b_ready;
  scan_t scan_b_data;
  // stage 4 result
  res_t  res;

  // stage 1: mask to the variable count, order the cubes, find differences,
  // saturate the distance
  cxl_order_stage u_order (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_i.valid),
    .ready_o       (in_i.ready),
    .first_bits_i  (in_i.first_cube_bits),
    .first_mask_i  (in_i.first_cube_mask),
    .second_bits_i (in_i.second_cube_bits),
    .second_mask_i (in_i.second_cube_mask),
    .dist_i        (in_i.link_distance),
    .codes_i       (in_i.choice_codes),
    .valid_o       (ord_valid),
    .ready_i       (ord_ready),
    .data_o        (ord_data)
  );

  // stage 2: first and second differing positions
  cxl_scan_stage u_scan_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ord_valid),
    .ready_o (ord_ready),
    .data_i  (ord_data),
    .valid_o (scan_a_valid),
    .ready_i (scan_a_ready),
    .data_o  (scan_a_data)
  );

  // stage 3: third and fourth differing positions
  cxl_scan_stage u_scan_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scan_a_valid),
    .ready_o (scan_a_ready),
    .data_i  (scan_a_data),
    .valid_o (scan_b_valid),
    .ready_i (scan_b_ready),
    .data_o  (scan_b_data)
  );

  // stage 4: apply the choice codes per result cube, output register
  cxl_compose_stage u_compose (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scan_b_valid),
    .ready_o (scan_b_ready),
    .data_i  (scan_b_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.out0_bits   = res.rbits[0];
  assign out_o.out0_mask   = res.rmask[0];
  assign out_o.out1_bits   = res.rbits[1];
  assign out_o.out1_mask   = res.rmask[1];
  assign out_o.out2_bits   = res.rbits[2];
  assign out_o.out2_mask   = res.rmask[2];
  assign out_o.out3_bits   = res.rbits[3];
  assign out_o.out3_mask   = res.rmask[3];
  assign out_o.valid_count = res.count;

endmodule

`default_nettype wire

[rtl/core/cxl_order_stage.sv]
`default_nettype none

module cxl_order_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire cxl_pkg::cube_w_t      first_bits_i,
  input  wire cxl_pkg::cube_w_t      first_mask_i,
  input  wire cxl_pkg::cube_w_t      second_bits_i,
  input  wire cxl_pkg::cube_w_t      second_mask_i,
  input  wire logic [2:0]            dist_i,
  input  wire logic [31:0]           codes_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output cxl_pkg::scan_t             data_o
);
  import cxl_pkg::*;

  logic    valid_q;
  scan_t   data_d, data_q;
  cube_w_t b0, m0, b1, m1;
  logic    swap;

  assign b0 = first_bits_i  & VAR_MASK;
  assign m0 = first_mask_i  & VAR_MASK;
  assign b1 = second_bits_i & VAR_MASK;
  assign m1 = second_mask_i & VAR_MASK;

  // key is mask above bits, unsigned; ties keep the first cube as base
  assign swap = {m1, b1} < {m0, b0};

  always_comb begin
    data_d.b0    = swap ? b1 : b0;
    data_d.m0    = swap ? m1 : m0;
    data_d.b1    = swap ? b0 : b1;
    data_d.m1    = swap ? m0 : m1;
    data_d.left  = (b0 ^ b1) | (m0 ^ m1);
    data_d.pos   = '0;
    data_d.span  = (dist_i > MAX_DISTANCE) ? MAX_DISTANCE : dist_i;
    data_d.codes = codes_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/core/cxl_scan_stage.sv]
`default_nettype none

module cxl_scan_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire cxl_pkg::scan_t   data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cxl_pkg::scan_t        data_o
);
  import cxl_pkg::*;

  logic    valid_q;
  scan_t   data_d, data_q;
  cube_w_t pa, pb, rest;

  // peel the two lowest remaining differing positions
  assign pa   = data_i.left & (-data_i.left);
  assign rest = data_i.left & ~pa;
  assign pb   = rest & (-rest);

  always_comb begin
    data_d        = data_i;
    data_d.left   = rest & ~pb;
    // earlier finds move to the low slots, new ones enter on top
    data_d.pos[0] = data_i.pos[2];
    data_d.pos[1] = data_i.pos[3];
    data_d.pos[2] = pa;
    data_d.pos[3] = pb;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[rtl/core/cxl_compose_stage.sv]
`default_nettype none

module cxl_compose_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire cxl_pkg::scan_t   data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output cxl_pkg::res_t         res_o
);
  import cxl_pkg::*;

  logic    valid_q;
  res_t    res_d, res_q;
  cube_w_t mbits, mmask;

  assign mbits = ~data_i.b0 & ~data_i.b1 & VAR_MASK;
  assign mmask = (data_i.m0 ^ data_i.m1) & VAR_MASK;

  always_comb begin
    logic [CODE_IDX_W-1:0] idx;
    logic [1:0]            code;
    cube_w_t               rb, rm, p;
    res_d       = '0;
    res_d.count = data_i.span;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      rb = data_i.b0;
      rm = data_i.m0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
        idx  = CODE_IDX_W'(i * int'(data_i.span) + j);
        code = data_i.codes[2*idx +: 2];
        p    = (j < int'(data_i.span)) ? data_i.pos[j] : '0;
        if (code == CODE_COPY) begin
          rb = (rb & ~p) | (data_i.b1 & p);
          rm = (rm & ~p) | (data_i.m1 & p);
        end else if (code == CODE_MERGE) begin
          rb = (rb & ~p) | (mbits & p);
          rm = (rm & ~p) | (mmask & p);
        end
      end
      if (i < int'(data_i.span)) begin
        res_d.rbits[i] = rb & VAR_MASK;
        res_d.rmask[i] = rm & VAR_MASK;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

[dv/cube_exorlink_checker.sv]
`timescale 1ns / 100ps

module cube_exorlink_checker
  import cxl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cxl_in_if           in_mon,
  cxl_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  localparam int unsigned MAX_REPORTS = 40;

  res_t        link_q[$];
  int unsigned fails;
  int unsigned checked;

  initial begin
    fails        = 0;
    checked      = 0;
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  // exorlink of one cube pair: base cube is the one with the lower {mask, bits}
  function automatic res_t link_cubes(cube_w_t fb, cube_w_t fm, cube_w_t sb, cube_w_t sm,
                                      logic [DIST_W-1:0] span_in,
                                      logic [CODE_W-1:0] codes);
    cube_w_t           b0, m0, b1, m1, tmp;
    cube_w_t           diff, mrg_b, mrg_m, rb, rm, left, p;
    logic [DIST_W-1:0] span;
    logic [3:0]        idx;
    logic [1:0]        code;
    res_t              r;
    b0 = fb & VAR_MASK;
    m0 = fm & VAR_MASK;
    b1 = sb & VAR_MASK;
    m1 = sm & VAR_MASK;
    span = (span_in > MAX_DISTANCE) ? MAX_DISTANCE : span_in;
    diff = (b0 ^ b1) | (m0 ^ m1);
    if ({m1, b1} < {m0, b0}) begin
      tmp = b0; b0 = b1; b1 = tmp;
      tmp = m0; m0 = m1; m1 = tmp;
    end
    mrg_b = ~b0 & ~b1 & VAR_MASK;
    mrg_m = (m0 ^ m1) & VAR_MASK;
    r = '0;
    for (int i = 0; i < int'(span); i++) begin
      rb   = b0;
      rm   = m0;
      left = diff;
      for (int j = 0; j < int'(span); j++) begin
        // lowest remaining differing position, empty once they run out
        p    = left & (~left + 1'b1);
        left = left & (left - 1'b1);
        idx  = 4'(i * int'(span) + j);
        code = codes[2*idx +: 2];
        case (code)
          CODE_COPY: begin
            rb = (rb & ~p) | (b1 & p);
            rm = (rm & ~p) | (m1 & p);
          end
          CODE_MERGE: begin
            rb = (rb & ~p) | (mrg_b & p);
            rm = (rm & ~p) | (mrg_m & p);
          end
          default: ;
        endcase
      end
      r.rbits[i] = rb & VAR_MASK;
      r.rmask[i] = rm & VAR_MASK;
    end
    r.count = span;
    return r;
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    fails++;
    if (fails <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %08h actual %08h", $time, what, want, got);
    if (fails == MAX_REPORTS)
      $display("%0t: report limit reached, further mismatches only counted", $time);
  endfunction

  always @(posedge clk_i) begin
    res_t want, got;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready)
        link_q.push_back(link_cubes(in_mon.first_cube_bits, in_mon.first_cube_mask,
                                    in_mon.second_cube_bits, in_mon.second_cube_mask,
                                    in_mon.link_distance, in_mon.choice_codes));
      if (out_mon.valid && out_mon.ready) begin
        got.rbits[0] = out_mon.out0_bits;
        got.rmask[0] = out_mon.out0_mask;
        got.rbits[1] = out_mon.out1_bits;
        got.rmask[1] = out_mon.out1_mask;
        got.rbits[2] = out_mon.out2_bits;
        got.rmask[2] = out_mon.out2_mask;
        got.rbits[3] = out_mon.out3_bits;
        got.rmask[3] = out_mon.out3_mask;
        got.count    = out_mon.valid_count;
        if (link_q.size() == 0) begin
          fails++;
          $display("%0t: result item with no pair outstanding, expected none actual count %0d",
                   $time, got.count);
        end else begin
          want = link_q.pop_front();
          for (int s = 0; s < SLOT_COUNT; s++) begin
            if (got.rbits[s] !== want.rbits[s])
              flag_mismatch($sformatf("out%0d_bits", s), want.rbits[s], got.rbits[s]);
            if (got.rmask[s] !== want.rmask[s])
              flag_mismatch($sformatf("out%0d_mask", s), want.rmask[s], got.rmask[s]);
          end
          if (got.count !== want.count)
            flag_mismatch("valid_count", 32'(want.count), 32'(got.count));
          checked++;
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= link_q.size();
    checked_o    <= checked;
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import cxl_pkg::*;

  // run shape
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned DRAIN_CYCLES = 16;

  // the fourth code value has no package name, it keeps the base literal
  localparam logic [1:0]        CODE_SPARE = 2'd3;
  localparam logic [CODE_W-1:0] ALL_KEEP   = {16{CODE_KEEP}};
  localparam logic [CODE_W-1:0] ALL_COPY   = {16{CODE_COPY}};
  localparam logic [CODE_W-1:0] ALL_MERGE  = {16{CODE_MERGE}};
  localparam logic [CODE_W-1:0] ALL_SPARE  = {16{CODE_SPARE}};
  localparam logic [CODE_W-1:0] MIXED      = {4{CODE_MERGE, CODE_COPY, CODE_SPARE, CODE_KEEP}};

  logic        clk_i;
  logic        rst_ni;

  // knobs set by the stimulus for the sender and the receiver process
  bit          gaps_on;
  bit          stalls_on;
  bit          long_hold_req;

  int unsigned cycle_cnt;
  int unsigned sent_cnt;
  int unsigned span_seen [8];
  int unsigned link_errors;
  int unsigned links_pending;
  int unsigned links_checked;

  cxl_in_if  in_if ();
  cxl_out_if out_if ();

  cube_exorlink_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // checker watches both channels, predicts each result and compares
  cube_exorlink_checker i_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (link_errors),
    .pending_o    (links_pending),
    .checked_o    (links_checked)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // a few random positions set, used to make the two cubes differ in a handful of places
  function automatic cube_w_t scatter_bits(int unsigned k);
    cube_w_t w;
    w = '0;
    repeat (k) w[$urandom_range(0, CUBE_W - 1)] = 1'b1;
    return w;
  endfunction

  // offer one cube pair and hold it until the block takes it
  task automatic send_pair(cube_w_t fb, cube_w_t fm, cube_w_t sb, cube_w_t sm,
                           logic [DIST_W-1:0] span, logic [CODE_W-1:0] codes);
    in_if.valid            <= 1'b1;
    in_if.first_cube_bits  <= fb;
    in_if.first_cube_mask  <= fm;
    in_if.second_cube_bits <= sb;
    in_if.second_cube_mask <= sm;
    in_if.link_distance    <= span;
    in_if.choice_codes     <= codes;
    do @(posedge clk_i); while (!in_if.ready);
    sent_cnt++;
    span_seen[span]++;
    // random gap on the sender side; valid stays up when there is none
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  // random pair: mostly near-identical cubes so the differing positions run out
  // around the distance, plus equal cubes, same-mask pairs and unrelated pairs
  task automatic send_random_pair();
    cube_w_t           fb, fm, sb, sm;
    logic [DIST_W-1:0] span;
    int unsigned       shape;
    fb    = $urandom;
    fm    = $urandom;
    shape = $urandom_range(0, 9);
    if (shape < 6) begin
      sb = fb ^ scatter_bits($urandom_range(0, 3));
      sm = fm ^ scatter_bits($urandom_range(0, 3));
    end else if (shape == 6) begin
      sb = fb;
      sm = fm;
    end else if (shape == 7) begin
      sb = fb ^ scatter_bits($urandom_range(1, 6));
      sm = fm;
    end else begin
      sb = $urandom;
      sm = $urandom;
    end
    if ($urandom_range(0, 9) == 0)
      span = DIST_W'($urandom_range(5, 7));
    else
      span = DIST_W'($urandom_range(0, 4));
    send_pair(fb, fm, sb, sm, span, $urandom);
  endtask

  // receiver: random stall bursts, plus one long hold-off counted here
  initial begin : sink_side
    int unsigned hold_left;
    logic        nxt;
    out_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        nxt           = 1'b0;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        hold_left = $urandom_range(1, 12) - 1;
        nxt       = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      out_if.ready <= nxt;
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still outstanding", cycle_cnt, links_pending);
    $display("** cube_exorlink_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    cube_w_t fb, fm;
    rst_ni                 = 1'b0;
    gaps_on                = 1'b0;
    stalls_on              = 1'b0;
    long_hold_req          = 1'b0;
    sent_cnt               = 0;
    foreach (span_seen[k]) span_seen[k] = 0;
    in_if.valid            = 1'b0;
    in_if.first_cube_bits  = '0;
    in_if.first_cube_mask  = '0;
    in_if.second_cube_bits = '0;
    in_if.second_cube_mask = '0;
    in_if.link_distance    = '0;
    in_if.choice_codes     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs, back to back with the receiver always ready
    send_pair('0, '0, '0, '0, 3'd0, '0);
    // equal all-ones cubes, distance saturates, every code is the spare keep
    send_pair('1, '1, '1, '1, 3'd7, ALL_SPARE);
    // first cube already lower: no swap
    send_pair('0, '0, '1, '1, 3'd4, ALL_COPY);
    // first cube higher: swapped
    send_pair('1, '1, '0, '0, 3'd4, ALL_COPY);
    send_pair(32'h0000_00F0, 32'h0000_FF00, 32'h0000_0F0F, 32'h0000_FFF0, 3'd4, ALL_MERGE);
    send_pair(32'h0000_00F0, 32'h0000_FF00, 32'h0000_0F0F, 32'h0000_FFF0, 3'd4, ALL_KEEP);
    send_pair($urandom, $urandom, $urandom, $urandom, 3'd4, MIXED);
    // a single differing position at the top bit, later visits find nothing left
    fb = $urandom;
    fm = $urandom;
    send_pair(fb, fm, fb ^ 32'h8000_0000, fm, 3'd4, ALL_COPY);
    // differing only at both ends of the word
    send_pair(fb, fm, fb ^ 32'h8000_0001, fm, 3'd3, ALL_MERGE);
    // identical cubes: keys tie, nothing differs
    send_pair(fb, fm, fb, fm, 3'd4, $urandom);
    // same mask, order decided by the polarity bits
    send_pair(32'h8000_0000, 32'h00FF_00FF, 32'h7FFF_FFFF, 32'h00FF_00FF, 3'd2, MIXED);
    // order decided by the mask even though the bits say otherwise
    send_pair('0, 32'h0000_0001, '1, '0, 3'd4, MIXED);
    // both masks full, merged literal on every visit
    send_pair(32'hA5A5_A5A5, '1, 32'h5A5A_5A5A, '1, 3'd4, ALL_MERGE);
    for (int s = 1; s < 8; s++)
      send_pair($urandom, $urandom, $urandom, $urandom, DIST_W'(s), $urandom);

    // random pairs with idling on both sides
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    for (int n = 0; n < 300; n++) send_random_pair();

    // receiver holds off while pairs keep coming, so the pipeline fills and backs up
    gaps_on       = 1'b0;
    long_hold_req = 1'b1;
    for (int n = 0; n < 24; n++) send_random_pair();

    gaps_on = 1'b1;
    for (int n = 0; n < 450; n++) send_random_pair();

    // closing stretch at full rate
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    for (int n = 0; n < 150; n++) send_random_pair();
    in_if.valid <= 1'b0;

    while (links_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d cube pairs, %0d results checked; distance 0..7 seen %0d %0d %0d %0d %0d %0d %0d %0d",
             sent_cnt, links_checked, span_seen[0], span_seen[1], span_seen[2], span_seen[3],
             span_seen[4], span_seen[5], span_seen[6], span_seen[7]);
    $display("all code values, swaps and ties, random idling on both sides, one %0d-cycle output hold",
             LONG_HOLD);
    if (link_errors == 0) begin
      $display("** cube_exorlink_unit: PASSED **");
    end else begin
      $display("%0d mismatches", link_errors);
      $display("** cube_exorlink_unit: FAILED **");
    end
    $finish;
  end

endmodule
